### rtl/glcd_pkg.sv
// ----------------------------------------------------------------------------
// glcd_pkg
// Shared types and constants for the learned GPIO change detector.
// ----------------------------------------------------------------------------
package glcd_pkg;

	// command codes of an input word
	localparam logic [1:0] CMD_OBSERVE = 2'd0;
	localparam logic [1:0] CMD_SETTLE  = 2'd1;
	localparam logic [1:0] CMD_UPDATE  = 2'd2;

	// result kinds
	localparam logic KIND_TRANSITION = 1'b0;
	localparam logic KIND_TOTAL      = 1'b1;

	// pin geometry of one port
	localparam int unsigned PINS_PER_PORT = 16;
	localparam int unsigned PIN_W         = 4;
	localparam int unsigned PORT_W        = 3;
	localparam int unsigned READING_W     = 32;
	localparam int unsigned TOTAL_W       = 8;
	localparam logic [READING_W-1:0] PIN_BITS = 32'h0000_FFFF;
	localparam logic [TOTAL_W-1:0]   TOTAL_MAX = 8'hFF;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COUNT,
		ST_TOTAL,
		ST_SCAN
	} glcd_state_t;

endpackage

### rtl/glcd_if.sv
// ----------------------------------------------------------------------------
// glcd_if
// Valid/ready channels of the learned GPIO change detector: reading words in,
// transition and total words out.
// ----------------------------------------------------------------------------
interface glcd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [2:0]  port;
	logic [31:0] reading;
	logic        end_of_snapshot;

	modport source (output valid, command, port, reading, end_of_snapshot, input ready);
	modport sink   (input valid, command, port, reading, end_of_snapshot, output ready);
endinterface

interface glcd_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [2:0] out_port;
	logic [3:0] out_pin;
	logic       level;
	logic [7:0] watched_total;
	logic       last;

	modport source (output valid, kind, out_port, out_pin, level, watched_total, last,
		input ready);
	modport sink   (input valid, kind, out_port, out_pin, level, watched_total, last,
		output ready);
endinterface

### rtl/gpio_learned_change_detector.sv
// ----------------------------------------------------------------------------
// gpio_learned_change_detector
// Learns per-port pin activity, fixes watch masks, then reports transitions.
// ----------------------------------------------------------------------------
// One word is taken at a time; the input is ready only while the sequencer is
// idle, and a finished result may still wait in the output register while the
// next word is taken. An observe word, and any word that causes no work, passes
// through capture and execute. A settle word of a present port then has the
// watched pins of the new mask counted one pin per cycle through a shared
// saturating incrementer; the snapshot-ending settle then loads the total
// word, waiting for a free output register. An update word with changes then
// scans one pin position per cycle, up to the highest changed pin (at most 16),
// walking the changed-pin shift register; a stalled output register holds the
// scan. Reset clears all learned state at once.
// ----------------------------------------------------------------------------
module gpio_learned_change_detector #(
	parameter int unsigned PORT_COUNT = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	glcd_in_if.sink         din,
	glcd_out_if.source      dout
);

	localparam int unsigned IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int unsigned NPIN  = glcd_pkg::PINS_PER_PORT;
	localparam int unsigned CMPW  = 5;

	glcd_pkg::glcd_state_t state_q, state_d;

	// captured input word
	logic [1:0]                  cmd_q;
	logic [glcd_pkg::PORT_W-1:0] port_q;
	logic [NPIN-1:0]             reading_lo_q;
	logic                        plausible_q;
	logic                        end_q;

	// per-port learned state
	logic [NPIN-1:0] seen_high_q [PORT_COUNT];
	logic [NPIN-1:0] seen_low_q  [PORT_COUNT];
	logic [NPIN-1:0] watch_mask_q [PORT_COUNT];
	logic [NPIN-1:0] prev_level_q [PORT_COUNT];
	logic            present_q [PORT_COUNT];
	logic            settled_q;
	logic [glcd_pkg::TOTAL_W-1:0] acc_q;

	// shared shift register and pin counter
	logic [NPIN-1:0]              work_q;
	logic [NPIN-1:0]              level_q;
	logic [glcd_pkg::PIN_W-1:0]   cnt_q;

	// output register
	logic                         out_valid_q;
	logic                         out_kind_q;
	logic [glcd_pkg::PORT_W-1:0]  out_port_q;
	logic [glcd_pkg::PIN_W-1:0]   out_pin_q;
	logic                         out_level_q;
	logic [glcd_pkg::TOTAL_W-1:0] out_total_q;
	logic                         out_last_q;

	// execute-stage decode
	logic [CMPW-1:0]  port_ext;
	logic [IDX_W-1:0] idx;
	logic             in_range;
	logic             learn_en;
	logic [NPIN-1:0]  sh_new, sl_new, mask_new, changed;
	logic             present_new;
	logic             upd_ok;

	// control
	logic accept, out_free, ld_total, ld_trans, scan_adv, count_step;

	assign accept   = din.valid && din.ready;
	assign out_free = !out_valid_q || dout.ready;

	assign port_ext = {2'b00, port_q};
	assign idx      = port_ext[IDX_W-1:0];
	assign in_range = port_ext < CMPW'(PORT_COUNT);

	// learning, mask and change computation for the captured word
	always_comb begin
		learn_en = in_range && !settled_q && plausible_q &&
			((cmd_q == glcd_pkg::CMD_OBSERVE) || (cmd_q == glcd_pkg::CMD_SETTLE));
		sh_new      = seen_high_q[idx];
		sl_new      = seen_low_q[idx];
		present_new = present_q[idx];
		if (learn_en) begin
			sh_new      = sh_new | reading_lo_q;
			sl_new      = sl_new | ~reading_lo_q;
			present_new = 1'b1;
		end
		mask_new = present_new ? ~(sh_new & sl_new) : '0;
		changed  = (reading_lo_q ^ prev_level_q[idx]) & watch_mask_q[idx];
		upd_ok   = (cmd_q == glcd_pkg::CMD_UPDATE) && settled_q && in_range && plausible_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			glcd_pkg::ST_IDLE: begin
				if (accept) state_d = glcd_pkg::ST_EXEC;
			end
			glcd_pkg::ST_EXEC: begin
				state_d = glcd_pkg::ST_IDLE;
				if (cmd_q == glcd_pkg::CMD_SETTLE) begin
					if (in_range && present_new) state_d = glcd_pkg::ST_COUNT;
					else if (end_q)              state_d = glcd_pkg::ST_TOTAL;
				end else if (upd_ok && (changed != '0)) begin
					state_d = glcd_pkg::ST_SCAN;
				end
			end
			glcd_pkg::ST_COUNT: begin
				if (cnt_q == glcd_pkg::PIN_W'(NPIN - 1))
					state_d = end_q ? glcd_pkg::ST_TOTAL : glcd_pkg::ST_IDLE;
			end
			glcd_pkg::ST_TOTAL: begin
				if (out_free) state_d = glcd_pkg::ST_IDLE;
			end
			glcd_pkg::ST_SCAN: begin
				if (scan_adv && (work_q[NPIN-1:1] == '0)) state_d = glcd_pkg::ST_IDLE;
			end
			default: state_d = glcd_pkg::ST_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		din.ready  = 1'b0;
		ld_total   = 1'b0;
		ld_trans   = 1'b0;
		scan_adv   = 1'b0;
		count_step = 1'b0;
		unique case (state_q)
			glcd_pkg::ST_IDLE:  din.ready  = 1'b1;
			glcd_pkg::ST_EXEC:  ;
			glcd_pkg::ST_COUNT: count_step = 1'b1;
			glcd_pkg::ST_TOTAL: ld_total   = out_free;
			glcd_pkg::ST_SCAN: begin
				scan_adv = !work_q[0] || out_free;
				ld_trans = work_q[0] && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= glcd_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// capture of the input word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= din.command;
			port_q       <= din.port;
			reading_lo_q <= din.reading[NPIN-1:0];
			plausible_q  <= (din.reading & ~glcd_pkg::PIN_BITS) == '0;
			end_q        <= din.end_of_snapshot;
		end
	end

	// learned per-port state, settled flag and watched-pin accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_COUNT; i++) begin
				seen_high_q[i]  <= '0;
				seen_low_q[i]   <= '0;
				watch_mask_q[i] <= '0;
				prev_level_q[i] <= '0;
				present_q[i]    <= 1'b0;
			end
			settled_q <= 1'b0;
			acc_q     <= '0;
		end else begin
			if (state_q == glcd_pkg::ST_EXEC) begin
				if (learn_en) begin
					seen_high_q[idx] <= sh_new;
					seen_low_q[idx]  <= sl_new;
					present_q[idx]   <= 1'b1;
				end
				if ((cmd_q == glcd_pkg::CMD_SETTLE) && in_range) begin
					watch_mask_q[idx] <= mask_new;
					prev_level_q[idx] <= reading_lo_q;
				end
				if (upd_ok) prev_level_q[idx] <= reading_lo_q;
			end
			// saturating count of watched pins, one pin per cycle
			if (count_step && work_q[0] && (acc_q != glcd_pkg::TOTAL_MAX))
				acc_q <= acc_q + 1'b1;
			if (ld_total) begin
				settled_q <= 1'b1;
				acc_q     <= '0;
			end
		end
	end

	// shared shift register and pin counter
	always_ff @(posedge clk) begin
		if (state_q == glcd_pkg::ST_EXEC) begin
			work_q  <= (cmd_q == glcd_pkg::CMD_SETTLE) ? mask_new : changed;
			level_q <= reading_lo_q;
			cnt_q   <= '0;
		end else if (count_step || scan_adv) begin
			work_q  <= work_q >> 1;
			level_q <= level_q >> 1;
			cnt_q   <= cnt_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (dout.valid && dout.ready) out_valid_q <= 1'b0;
			if (ld_total || ld_trans)     out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_total) begin
			out_kind_q  <= glcd_pkg::KIND_TOTAL;
			out_port_q  <= '0;
			out_pin_q   <= '0;
			out_level_q <= 1'b0;
			out_total_q <= acc_q;
			out_last_q  <= 1'b1;
		end else if (ld_trans) begin
			out_kind_q  <= glcd_pkg::KIND_TRANSITION;
			out_port_q  <= port_q;
			out_pin_q   <= cnt_q;
			out_level_q <= level_q[0];
			out_total_q <= '0;
			out_last_q  <= work_q[NPIN-1:1] == '0;
		end
	end

	assign dout.valid         = out_valid_q;
	assign dout.kind          = out_kind_q;
	assign dout.out_port      = out_port_q;
	assign dout.out_pin       = out_pin_q;
	assign dout.level         = out_level_q;
	assign dout.watched_total = out_total_q;
	assign dout.last          = out_last_q;

	// scanning only runs while changed pins remain
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == glcd_pkg::ST_SCAN |-> work_q != '0)
		else $error("scan state entered with no changed pins");

	// total word latches settled and clears the accumulator
	a_total_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ld_total |=> (settled_q && acc_q == '0))
		else $error("total word did not settle and clear accumulator");

	// a total word always ends its input's results
	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.kind == glcd_pkg::KIND_TOTAL) |-> dout.last)
		else $error("total word without last");

	// pin counting starts from pin zero
	a_count_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == glcd_pkg::ST_COUNT) |-> cnt_q == '0)
		else $error("pin count phase did not start at pin zero");

endmodule

### test/glcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcd_checker
// Watches both channels of the learned GPIO change detector, keeps its own
// copy of the learned pin state, predicts the result words of every accepted
// reading word and compares each delivered word, field by field, with the
// oldest one still due.
// ----------------------------------------------------------------------------
module glcd_checker (
	input  logic clk,
	input  logic arst_n,
	glcd_in_if   din,
	glcd_out_if  dout,
	output int   fail_count,
	output int   pending
);

	localparam int NPORT = 8;

	typedef struct packed {
		logic       kind;
		logic [2:0] port;
		logic [3:0] pin;
		logic       level;
		logic [7:0] total;
		logic       last;
	} pin_event_t;

	// learned pin activity and watch state per port
	logic [15:0] went_high [NPORT];
	logic [15:0] went_low [NPORT];
	logic        answered [NPORT];
	logic [15:0] watched_pins [NPORT];
	logic [15:0] last_pins [NPORT];
	logic        latched;
	logic [7:0]  watched_tally;

	pin_event_t events_due[$];
	int errs = 0;

	always @(posedge clk or negedge arst_n) begin : predictor
		pin_event_t want, got;
		logic [15:0] low_half, changed;
		int unsigned sum;
		int p;
		if (!arst_n) begin
			for (int i = 0; i < NPORT; i++) begin
				went_high[i] = '0;
				went_low[i] = '0;
				answered[i] = 1'b0;
				watched_pins[i] = '0;
				last_pins[i] = '0;
			end
			latched = 1'b0;
			watched_tally = '0;
			events_due.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			// delivered word against the oldest one due
			if (dout.valid === 1'b1 && dout.ready === 1'b1) begin
				got = {dout.kind, dout.out_port, dout.out_pin, dout.level,
					dout.watched_total, dout.last};
				if (events_due.size() == 0) begin
					errs++;
					$display("%0t: result word with none due, expected none, got",
						$time, " kind=%0d port=%0d pin=%0d level=%0d total=%0d last=%0d",
						got.kind, got.port, got.pin, got.level, got.total, got.last);
				end else begin
					want = events_due.pop_front();
					if (got.kind !== want.kind || got.port !== want.port ||
						got.pin !== want.pin || got.level !== want.level ||
						got.total !== want.total || got.last !== want.last) begin
						errs++;
						$display("%0t: result word mismatch", $time);
						$display("  expected kind=%0d port=%0d pin=%0d level=%0d total=%0d last=%0d",
							want.kind, want.port, want.pin, want.level, want.total, want.last);
						$display("  actual   kind=%0d port=%0d pin=%0d level=%0d total=%0d last=%0d",
							got.kind, got.port, got.pin, got.level, got.total, got.last);
					end
				end
			end

			// step the learned state with an accepted reading word
			if (din.valid === 1'b1 && din.ready === 1'b1) begin
				p = int'(din.port);
				low_half = din.reading[15:0];

				// learning only before the snapshot latches, on answering ports
				if ((din.command == glcd_pkg::CMD_OBSERVE ||
					din.command == glcd_pkg::CMD_SETTLE) &&
					!latched && din.reading[31:16] == '0) begin
					answered[p] = 1'b1;
					went_high[p] |= low_half;
					went_low[p] |= ~low_half;
				end

				if (din.command == glcd_pkg::CMD_SETTLE) begin
					// pins seen at both levels drop out of the watch set
					if (answered[p]) begin
						watched_pins[p] = ~(went_high[p] & went_low[p]);
						sum = watched_tally + $countones(watched_pins[p]);
						watched_tally = (sum > glcd_pkg::TOTAL_MAX) ? glcd_pkg::TOTAL_MAX
							: sum[7:0];
					end else begin
						watched_pins[p] = '0;
					end
					last_pins[p] = low_half;
					if (din.end_of_snapshot) begin
						latched = 1'b1;
						want = {glcd_pkg::KIND_TOTAL, 3'd0, 4'd0, 1'b0, watched_tally, 1'b1};
						events_due.push_back(want);
						watched_tally = '0;
					end
				end else if (din.command == glcd_pkg::CMD_UPDATE && latched &&
					din.reading[31:16] == '0) begin
					// one transition per changed watched pin, lowest pin first
					changed = (low_half ^ last_pins[p]) & watched_pins[p];
					last_pins[p] = low_half;
					for (int i = 0; i < 16; i++) begin
						if (changed[i]) begin
							want = {glcd_pkg::KIND_TRANSITION, din.port, 4'(i), low_half[i],
								8'd0, (changed >> (i + 1)) == 16'd0};
							events_due.push_back(want);
						end
					end
				end
			end

			fail_count <= errs;
			pending <= events_due.size();
		end
	end

endmodule

### test/tb_gpio_learned_change_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gpio_learned_change_detector
// Drives reading words into the learned GPIO change detector: a directed pass
// through learning, settling and the corner cases, then random update bursts,
// fresh snapshots and noise, with random gaps on both channels. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_gpio_learned_change_detector;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TOTAL_WORDS = 110;
	localparam int SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int unsigned cycles = 0;
	bit calm = 1'b0;
	int counted = 0;

	// last low half put on each port by a settle or an answering update
	logic [15:0] last_level [8];

	glcd_in_if  din_ch ();
	glcd_out_if dout_ch ();

	gpio_learned_change_detector #(
		.PORT_COUNT(8)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	glcd_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din_ch),
		.dout       (dout_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_gpio_learned_change_detector failed");
			$finish;
		end
	end

	// result side: random stall before taking each word
	initial begin : drain
		int stall;
		dout_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				dout_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_ch.ready <= 1'b1;
			do @(posedge clk); while (dout_ch.valid !== 1'b1);
		end
	end

	// one reading word, after a random gap; valid stays up when no gap follows
	task automatic send_word(input logic [1:0] cmd, input logic [2:0] port,
		input logic [31:0] rd, input logic eos);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid <= 1'b1;
		din_ch.command <= cmd;
		din_ch.port <= port;
		din_ch.reading <= rd;
		din_ch.end_of_snapshot <= eos;
		do @(posedge clk); while (din_ch.ready !== 1'b1);
		if (cmd == glcd_pkg::CMD_SETTLE ||
			(cmd == glcd_pkg::CMD_UPDATE && rd[31:16] == '0)) begin
			last_level[port] = rd[15:0];
		end
		counted++;
	endtask

	// hold the input idle until every due word has come out
	task automatic drain_pause();
		din_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// a new pin pattern near the last one seen on a port
	function automatic logic [15:0] nudge(input logic [15:0] base);
		logic [15:0] flips;
		case ($urandom_range(0, 3))
			0: flips = '0;
			1: flips = 16'd1 << $urandom_range(0, 15);
			2: flips = 16'($urandom) & 16'($urandom);
			default: flips = 16'($urandom);
		endcase
		return base ^ flips;
	endfunction

	function automatic logic [31:0] dead_reading();
		return $urandom | (32'd1 << $urandom_range(16, 31));
	endfunction

	initial begin : stimulus
		logic [2:0] p;
		int n;
		arst_n <= 1'b0;
		din_ch.valid <= 1'b0;
		din_ch.command <= glcd_pkg::CMD_OBSERVE;
		din_ch.port <= '0;
		din_ch.reading <= '0;
		din_ch.end_of_snapshot <= 1'b0;
		for (int i = 0; i < 8; i++) last_level[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// learning phase: dead ports, ignored codes, update before settling
		send_word(glcd_pkg::CMD_UPDATE, 3'd0, 32'h0000_FFFF, 1'b0);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd0, 32'hFFFF_0000, 1'b0);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd0, 32'h0000_FFFF, 1'b0);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd0, 32'h0000_00F0, 1'b0);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd7, 32'h0000_0000, 1'b1);
		send_word(CMD_UNUSED, 3'd2, 32'hFFFF_FFFF, 1'b1);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd1, 32'h0000_0000, 1'b0);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd2, 32'h0000_FFFF, 1'b0);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd4, 32'h8000_0001, 1'b0);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd5, 32'h0000_5555, 1'b0);
		send_word(glcd_pkg::CMD_OBSERVE, 3'd6, 32'h0000_AAAA, 1'b0);

		// snapshot: absent port, dead reading on settle, ports 4 left out
		send_word(glcd_pkg::CMD_SETTLE, 3'd3, 32'h0000_A5A5, 1'b0);
		send_word(glcd_pkg::CMD_SETTLE, 3'd0, 32'h0000_1234, 1'b0);
		send_word(glcd_pkg::CMD_SETTLE, 3'd1, 32'h0000_0F0F, 1'b0);
		send_word(glcd_pkg::CMD_SETTLE, 3'd2, 32'h0000_FF00, 1'b0);
		send_word(glcd_pkg::CMD_SETTLE, 3'd5, 32'h0000_5555, 1'b0);
		send_word(glcd_pkg::CMD_SETTLE, 3'd6, 32'hFFFF_FFFF, 1'b0);
		send_word(glcd_pkg::CMD_SETTLE, 3'd7, 32'h0000_0000, 1'b1);

		// after settling: observe ignored, full flips, no change, dead update
		send_word(glcd_pkg::CMD_OBSERVE, 3'd4, 32'h0000_1111, 1'b0);
		send_word(glcd_pkg::CMD_UPDATE, 3'd5, 32'h0000_AAAA, 1'b0);
		send_word(glcd_pkg::CMD_UPDATE, 3'd5, 32'h0000_AAAA, 1'b1);
		send_word(glcd_pkg::CMD_UPDATE, 3'd6, 32'hFFFF_0000, 1'b0);
		send_word(glcd_pkg::CMD_UPDATE, 3'd6, 32'h0000_0000, 1'b0);
		send_word(glcd_pkg::CMD_UPDATE, 3'd1, 32'h0000_F0F0, 1'b0);
		send_word(glcd_pkg::CMD_SETTLE, 3'd5, 32'h0000_0000, 1'b0);

		drain_pause();

		// tally saturation: fully watched port settled over and over
		for (int k = 0; k < 17; k++) begin
			send_word(glcd_pkg::CMD_SETTLE, 3'd5, {16'h0, 16'($urandom)}, k == 16);
		end

		// random part
		while (counted < TOTAL_WORDS) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					// burst of updates on one port
					p = 3'($urandom_range(0, 7));
					n = $urandom_range(1, 6);
					repeat (n) begin
						send_word(glcd_pkg::CMD_UPDATE, p, {16'h0, nudge(last_level[p])},
							1'($urandom_range(0, 1)));
					end
				end
				5, 6: begin
					// fresh snapshot over some ports, end mark on the last
					n = $urandom_range(1, 8);
					for (int k = 0; k < n; k++) begin
						p = 3'($urandom_range(0, 7));
						send_word(glcd_pkg::CMD_SETTLE, p,
							($urandom_range(0, 5) == 0) ? dead_reading()
								: {16'h0, nudge(last_level[p])},
							k == n - 1);
					end
				end
				7: begin
					// noise
					repeat ($urandom_range(1, 4)) begin
						p = 3'($urandom_range(0, 7));
						case ($urandom_range(0, 3))
							0: send_word(glcd_pkg::CMD_OBSERVE, p, $urandom,
								1'($urandom_range(0, 1)));
							1: send_word(CMD_UNUSED, p, $urandom, 1'($urandom_range(0, 1)));
							2: send_word(glcd_pkg::CMD_UPDATE, p, dead_reading(),
								1'($urandom_range(0, 1)));
							default: send_word(glcd_pkg::CMD_SETTLE, p,
								{16'h0, 16'($urandom)}, 1'b0);
						endcase
					end
				end
				8: begin
					// settle without end mark: tally may grow, no word out
					p = 3'($urandom_range(0, 7));
					send_word(glcd_pkg::CMD_SETTLE, p, {16'h0, nudge(last_level[p])}, 1'b0);
				end
				default: begin
					// let everything drain, then resume with an update burst
					drain_pause();
					p = 3'($urandom_range(0, 7));
					repeat ($urandom_range(1, 4)) begin
						send_word(glcd_pkg::CMD_UPDATE, p, {16'h0, nudge(last_level[p])},
							1'b0);
					end
				end
			endcase
		end

		// wind down
		din_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_gpio_learned_change_detector passed");
		end else begin
			$display("tb_gpio_learned_change_detector failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/glcd_pkg.sv
rtl/glcd_if.sv
rtl/gpio_learned_change_detector.sv
test/glcd_checker.sv
test/tb_gpio_learned_change_detector.sv
